// ===== hw/rtl/sjfbe_pkg.sv =====
// Shared types and constants for the shortest-job-first burst estimate block.
// Holds the word structs, the operation codes and the default sizes.
// Has no dependencies; every other file of the block imports it.
package sjfbe_pkg;

	// Default sizes, handed to the top level as parameter defaults.
	localparam int ENTRIES_DEF   = 64;
	localparam int TICK_BITS_DEF = 32;

	// Fixed field widths of the words.
	localparam int INDEX_W    = 6;
	localparam int EST_OUT_W  = 32;
	localparam int BURST_W    = 32;
	localparam int WEIGHT_W   = 4;

	// Weight scale (tenths) and the weight register's reset value.
	localparam logic [WEIGHT_W-1:0] WEIGHT_SCALE = 4'd10;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd5;

	// Operation codes carried in the func field.
	localparam logic [1:0] FUNC_SET    = 2'd0;
	localparam logic [1:0] FUNC_SELECT = 2'd1;
	localparam logic [1:0] FUNC_BURST  = 2'd2;
	localparam logic [1:0] FUNC_NOP    = 2'd3;

	// Input word.
	typedef struct packed {
		logic [1:0]         func;
		logic [INDEX_W-1:0] entry_index;
		logic               make_runnable;
		logic               clear_estimate;
		logic [BURST_W-1:0] burst_ticks;
	} sjfbe_in_t;

	// Output word.
	typedef struct packed {
		logic [INDEX_W-1:0]   chosen_index;
		logic                 found;
		logic [EST_OUT_W-1:0] estimate_value;
	} sjfbe_out_t;

	// Scan token that walks down the row of cells.
	typedef struct packed {
		logic valid;
		logic have;
	} sjfbe_tok_t;

	// Write-back command broadcast to every cell.
	typedef struct packed {
		logic en;
		logic set_flag;
		logic flag;
		logic set_est;
	} sjfbe_wr_t;

endpackage

// ===== hw/rtl/sjfbe_cell.sv =====
// One table entry of the burst estimate block: runnable flag, estimate and a
// stage of the scan token path. Depends on sjfbe_pkg.
module sjfbe_cell import sjfbe_pkg::*; #(
	parameter int MY_IDX    = 0,
	parameter int IDXW      = 6,
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_sel,
	input  logic [INDEX_W-1:0]   op_idx,
	input  sjfbe_tok_t           tok_in,
	input  logic [IDXW-1:0]      idx_in,
	input  logic [TICK_BITS-1:0] est_in,
	output sjfbe_tok_t           tok_out,
	output logic [IDXW-1:0]      idx_out,
	output logic [TICK_BITS-1:0] est_out,
	input  sjfbe_wr_t            wr,
	input  logic [IDXW-1:0]      wr_idx,
	input  logic [TICK_BITS-1:0] wr_est
);

	localparam int CW = (IDXW > INDEX_W) ? IDXW : INDEX_W;

	logic                 flag_q;
	logic [TICK_BITS-1:0] est_q;
	sjfbe_tok_t           tok_q;
	logic [IDXW-1:0]      idx_q;
	logic [TICK_BITS-1:0] carry_est_q;
	logic                 hit_addr;
	logic                 take;

	// A select takes the entry when it is runnable and strictly smaller than the
	// best so far, so ties stay with the lower index. Other operations take the
	// addressed entry only.
	assign hit_addr = (CW'(op_idx) == CW'(MY_IDX));
	assign take     = tok_in.valid &&
		(op_sel ? (flag_q && (!tok_in.have || (est_q < est_in))) : hit_addr);

	// Token stage towards the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.have  <= tok_in.have | take;
		end
	end

	// Candidate carried along with the token.
	always_ff @(posedge clk) begin
		idx_q       <= take ? IDXW'(MY_IDX) : idx_in;
		carry_est_q <= take ? est_q : est_in;
	end

	// Entry state, updated by the broadcast write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			est_q  <= '0;
		end else if (wr.en && (wr_idx == IDXW'(MY_IDX))) begin
			if (wr.set_flag) begin
				flag_q <= wr.flag;
			end
			if (wr.set_est) begin
				est_q <= wr_est;
			end
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;
	assign est_out = carry_est_q;

endmodule

// ===== hw/rtl/sjfbe_blend.sv =====
// Estimate blend unit: ((10-w)*estimate + w*burst)/10 with floor. The division
// by ten is a shift-and-add reciprocal, refined step by step.
// Depends on sjfbe_pkg.
module sjfbe_blend import sjfbe_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WEIGHT_W-1:0]  weight,
	input  logic [TICK_BITS-1:0] est,
	input  logic [TICK_BITS-1:0] burst,
	output logic                 done,
	output logic [TICK_BITS-1:0] result
);

	localparam int SW = TICK_BITS + 4;
	localparam logic [2:0] LAST_STEP = 3'd6;

	logic [WEIGHT_W-1:0]  w_sat;
	logic [WEIGHT_W-1:0]  w_inv;
	logic [SW-1:0]        sum;
	logic [SW-1:0]        sum_q;
	logic [SW-1:0]        quo_q;
	logic [SW-1:0]        quo_n;
	logic [SW-1:0]        rem;
	logic [2:0]           step_q;
	logic                 run_q;
	logic                 done_q;

	// Weight saturates at ten; the weighted sum fits in four extra bits.
	assign w_sat = (weight > WEIGHT_SCALE) ? WEIGHT_SCALE : weight;
	assign w_inv = WEIGHT_SCALE - w_sat;
	assign sum   = (SW'(w_inv) * SW'(est)) + (SW'(w_sat) * SW'(burst));

	// Remainder left by the estimated quotient. The estimate is never more
	// than one too small, so the remainder stays below twenty.
	assign rem = sum_q - ((quo_q << 3) + (quo_q << 1));

	// The quotient is first built as sum*0.8 by doubling shifts, then scaled
	// down by eight and raised by one where the remainder reaches ten.
	always_comb begin
		case (step_q)
			3'd0: quo_n = (sum_q >> 1) + (sum_q >> 2);
			3'd1: quo_n = quo_q + (quo_q >> 4);
			3'd2: quo_n = quo_q + (quo_q >> 8);
			3'd3: quo_n = quo_q + (quo_q >> 16);
			3'd4: quo_n = quo_q + (quo_q >> 32);
			3'd5: quo_n = quo_q >> 3;
			3'd6: quo_n = quo_q + SW'(rem >= SW'(WEIGHT_SCALE));
			default: quo_n = quo_q;
		endcase
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == LAST_STEP) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Weighted sum captured at the start, quotient refined one step a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			sum_q <= sum;
			quo_q <= '0;
		end else if (run_q) begin
			quo_q <= quo_n;
		end
	end

	assign done   = done_q;
	assign result = quo_q[TICK_BITS-1:0];

endmodule

// ===== hw/rtl/sjf_scheduler_burst_estimate_core.sv =====
// Shortest-job-first picker with exponentially averaged burst estimates.
// Uses the row of entry cells and the blend unit. Depends on sjfbe_pkg.
//
// Use: one input channel and one output channel, both valid/ready, and a
// write-only port for the blend weight (cfg_we, cfg_wdata), written while idle.
// Each input word gives exactly one output word. Set entry writes a runnable
// flag and may clear the estimate; select picks the runnable entry with the
// smallest estimate, lowest index on a tie, and marks it not runnable; burst
// done blends the measured burst into the estimate and writes the flag.
// Every word walks a token through the row of ENTRIES cells, one cell a
// cycle; the scan outcome is registered at the end of the row, and the
// result word is then loaded into the output register. A burst done on an
// entry inside the table also passes through the blend unit for the
// weighted sum and the division by ten. One item is in work at a time; the
// next is accepted once the result has moved to the output register.
// If the receiver stalls, that result waits in the output register, a
// following item is still accepted and worked, and its result waits until the
// register frees. Reset clears every flag and estimate, sets the weight to
// five and empties the output register; no clearing pass is needed.
module sjf_scheduler_burst_estimate_core import sjfbe_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sjfbe_in_t           in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sjfbe_out_t          out_data,
	input  logic                cfg_we,
	input  logic [WEIGHT_W-1:0] cfg_wdata
);

	localparam int IDXW = $clog2(ENTRIES);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_BLEND = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t               state_q;
	logic                 start_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic [1:0]           func_q;
	logic [INDEX_W-1:0]   eidx_q;
	logic                 mk_q;
	logic                 clr_q;
	logic [TICK_BITS-1:0] burst_q;
	logic                 have_end_q;
	logic [IDXW-1:0]      idx_end_q;
	logic [TICK_BITS-1:0] est_end_q;
	logic                 out_valid_q;
	sjfbe_out_t           out_data_q;

	sjfbe_tok_t           tok_c [ENTRIES+1];
	logic [IDXW-1:0]      idx_c [ENTRIES+1];
	logic [TICK_BITS-1:0] est_c [ENTRIES+1];
	logic [ENTRIES-1:0]   tok_vec;

	logic                 accept;
	logic                 scan_end;
	logic                 blend_start;
	logic                 blend_done;
	logic [TICK_BITS-1:0] blend_res;
	logic                 load;
	sjfbe_out_t           result;
	sjfbe_wr_t            wr;
	logic [TICK_BITS-1:0] wr_est;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign scan_end = (state_q == ST_SCAN) && tok_c[ENTRIES].valid;
	assign load     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Blend only when the addressed entry exists in the table.
	assign blend_start = scan_end && (func_q == FUNC_BURST) && tok_c[ENTRIES].have;

	// Weight register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (cfg_we) begin
			weight_q <= cfg_wdata;
		end
	end

	// Sequencer: scan the row, blend if needed, then hand over the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= blend_start ? ST_BLEND : ST_DONE;
					end
				end
				ST_BLEND: begin
					if (blend_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item fields held for the whole operation, and the scan outcome.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_data.func;
			eidx_q  <= in_data.entry_index;
			mk_q    <= in_data.make_runnable;
			clr_q   <= in_data.clear_estimate;
			burst_q <= TICK_BITS'(in_data.burst_ticks);
		end
		if (scan_end) begin
			have_end_q <= tok_c[ENTRIES].have;
			idx_end_q  <= idx_c[ENTRIES];
			est_end_q  <= est_c[ENTRIES];
		end
	end

	// Row of entry cells; the token enters at cell zero with no candidate.
	assign tok_c[0] = '{valid: start_q, have: 1'b0};
	assign idx_c[0] = '0;
	assign est_c[0] = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		sjfbe_cell #(
			.MY_IDX    (g),
			.IDXW      (IDXW),
			.TICK_BITS (TICK_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op_sel  (func_q == FUNC_SELECT),
			.op_idx  (eidx_q),
			.tok_in  (tok_c[g]),
			.idx_in  (idx_c[g]),
			.est_in  (est_c[g]),
			.tok_out (tok_c[g+1]),
			.idx_out (idx_c[g+1]),
			.est_out (est_c[g+1]),
			.wr      (wr),
			.wr_idx  (idx_end_q),
			.wr_est  (wr_est)
		);
		assign tok_vec[g] = tok_c[g+1].valid;
	end

	// Shared blend unit, started from the scan outcome at the end of the row.
	sjfbe_blend #(
		.TICK_BITS (TICK_BITS)
	) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.weight (weight_q),
		.est    (est_c[ENTRIES]),
		.burst  (burst_q),
		.done   (blend_done),
		.result (blend_res)
	);

	// Result word and write-back command, both issued when the word is loaded.
	always_comb begin
		result = '0;
		wr     = '0;
		wr_est = '0;
		case (func_q)
			FUNC_SELECT: begin
				result.chosen_index   = INDEX_W'(idx_end_q);
				result.found          = have_end_q;
				result.estimate_value = EST_OUT_W'(est_end_q);
				wr.en                 = load && have_end_q;
				wr.set_flag           = 1'b1;
				wr.flag               = 1'b0;
			end
			FUNC_SET: begin
				result.chosen_index   = eidx_q;
				result.found          = 1'b1;
				result.estimate_value = clr_q ? '0 : EST_OUT_W'(est_end_q);
				wr.en                 = load && have_end_q;
				wr.set_flag           = 1'b1;
				wr.flag               = mk_q;
				wr.set_est            = clr_q;
			end
			FUNC_BURST: begin
				result.chosen_index   = eidx_q;
				result.found          = 1'b1;
				result.estimate_value = have_end_q ? EST_OUT_W'(blend_res) : '0;
				wr.en                 = load && have_end_q;
				wr.set_flag           = 1'b1;
				wr.flag               = mk_q;
				wr.set_est            = 1'b1;
				wr_est                = blend_res;
			end
			default: begin
				result.chosen_index   = eidx_q;
				result.found          = 1'b1;
				result.estimate_value = EST_OUT_W'(est_end_q);
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// At most one token is ever in the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one scan token in the cell row");

	// The token leaves the row only while the sequencer waits for it.
	a_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		tok_c[ENTRIES].valid |-> (state_q == ST_SCAN))
		else $error("scan token left the row outside the scan state");

	// A failed select reports index zero and estimate zero.
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.found) |->
		(out_data.chosen_index == '0) && (out_data.estimate_value == '0))
		else $error("failed select carries a non-zero index or estimate");

	// The blend unit finishes only while the sequencer waits for it.
	a_blend_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(blend_done) |-> (state_q == ST_BLEND))
		else $error("blend finished outside the blend state");

endmodule

// ===== sim/sjf_scheduler_burst_estimate_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the shortest-job-first burst estimate core.
// It holds a predictor of the entry table, a valid/ready driver and a checking monitor.
// Depends on sjfbe_pkg and sjf_scheduler_burst_estimate_core.
module sjf_scheduler_burst_estimate_core_tb;
	import sjfbe_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 150;
	localparam int PHASE_WORDS = 144;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	sjfbe_in_t           in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	sjfbe_out_t          out_data;
	logic                cfg_we    = 1'b0;
	logic [WEIGHT_W-1:0] cfg_wdata = '0;

	sjf_scheduler_burst_estimate_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted table contents and the blend weight in force.
	logic                 task_ready [ENTRIES_DEF];
	logic [BURST_W-1:0]   task_est   [ENTRIES_DEF];
	logic [WEIGHT_W-1:0]  blend_w = WEIGHT_RESET;

	// Jobs waiting to be offered and result words waiting to come out.
	sjfbe_in_t  job_queue [$];
	sjfbe_out_t due_words [$];

	int err_count   = 0;
	int n_words     = 0;
	int n_selects   = 0;
	int n_none      = 0;
	int n_bursts    = 0;
	int n_weights   = 0;
	int tx_idle     = 0;
	int tx_calm     = 0;
	int rx_stall    = 0;
	int rx_calm     = 0;
	int quiet_count = 0;

	initial begin
		for (int i = 0; i < ENTRIES_DEF; i++) begin
			task_ready[i] = 1'b0;
			task_est[i]   = '0;
		end
	end

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Applies one job to the predicted table and returns the word it should give.
	function automatic sjfbe_out_t schedule_step(sjfbe_in_t j);
		sjfbe_out_t          r;
		int                  best;
		int                  idx;
		logic [WEIGHT_W-1:0] wt;
		logic [63:0]         mix;
		best             = -1;
		idx              = int'(j.entry_index);
		r.chosen_index   = j.entry_index;
		r.found          = 1'b1;
		r.estimate_value = task_est[idx];
		case (j.func)
			FUNC_SELECT: begin
				for (int i = 0; i < ENTRIES_DEF; i++)
					if (task_ready[i] && (best < 0 || task_est[i] < task_est[best]))
						best = i;
				if (best < 0) begin
					r.chosen_index   = '0;
					r.found          = 1'b0;
					r.estimate_value = '0;
				end else begin
					task_ready[best] = 1'b0;
					r.chosen_index   = INDEX_W'(best);
					r.estimate_value = task_est[best];
				end
			end
			FUNC_SET: begin
				task_ready[idx] = j.make_runnable;
				if (j.clear_estimate)
					task_est[idx] = '0;
				r.estimate_value = task_est[idx];
			end
			FUNC_BURST: begin
				// The weight saturates at ten when it is applied.
				wt  = (blend_w > WEIGHT_SCALE) ? WEIGHT_SCALE : blend_w;
				mix = 64'(WEIGHT_SCALE - wt) * 64'(task_est[idx])
					+ 64'(wt) * 64'(j.burst_ticks);
				task_est[idx]    = BURST_W'(mix / 64'(WEIGHT_SCALE));
				task_ready[idx]  = j.make_runnable;
				r.estimate_value = task_est[idx];
			end
			default: begin
				// The unused code only reports the addressed entry.
			end
		endcase
		return r;
	endfunction

	// Idle length: mostly short, a few long, with calm stretches of none at all.
	function automatic int idle_len(inout int calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 3) begin
			calm = $urandom_range(20, 40);
			return 0;
		end
		if (roll < 45)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic sjfbe_in_t make_job(logic [1:0] f, int idx, bit mk, bit clr,
			logic [BURST_W-1:0] ticks);
		sjfbe_in_t j;
		j.func           = f;
		j.entry_index    = INDEX_W'(idx);
		j.make_runnable  = mk;
		j.clear_estimate = clr;
		j.burst_ticks    = ticks;
		return j;
	endfunction

	// Random job: mostly bursts and selects on a crowded corner of the table,
	// so that ties and nearby estimates are common.
	function automatic sjfbe_in_t rand_job();
		sjfbe_in_t j;
		int        roll;
		roll             = $urandom_range(0, 99);
		j.entry_index    = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 7))
			: INDEX_W'($urandom);
		j.make_runnable  = ($urandom_range(0, 4) != 0);
		j.clear_estimate = ($urandom_range(0, 2) == 0);
		case ($urandom_range(0, 3))
			0: j.burst_ticks = $urandom_range(0, 1000);
			1: j.burst_ticks = $urandom_range(0, 1) ? '1 : '0;
			default: j.burst_ticks = $urandom;
		endcase
		if (roll < 38)
			j.func = FUNC_BURST;
		else if (roll < 70)
			j.func = FUNC_SELECT;
		else if (roll < 94) begin
			j.func          = FUNC_SET;
			j.make_runnable = 1'($urandom_range(0, 1));
		end else
			j.func = FUNC_NOP;
		return j;
	endfunction

	// Input side: hold a word until it is taken, then idle or offer the next.
	always @(posedge clk) begin : tx_side
		logic nxt_valid;
		nxt_valid = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				due_words.push_back(schedule_step(in_data));
				n_words++;
				if (in_data.func == FUNC_SELECT)
					n_selects++;
				if (in_data.func == FUNC_BURST)
					n_bursts++;
			end
			if (!(in_valid && !in_ready)) begin
				if (tx_idle > 0) begin
					tx_idle--;
					nxt_valid = 1'b0;
				end else if (job_queue.size() != 0) begin
					in_data   <= job_queue.pop_front();
					nxt_valid = 1'b1;
					tx_idle   = idle_len(tx_calm);
				end else
					nxt_valid = 1'b0;
			end
		end
		in_valid <= nxt_valid;
	end

	// Output side: random back-pressure and a field-by-field check of each word.
	always @(posedge clk) begin : rx_side
		sjfbe_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					$display("%0t: unexpected output word %h", $time, out_data);
					err_count++;
				end else begin
					want = due_words.pop_front();
					if (want.estimate_value == '0 && !want.found)
						n_none++;
					if (out_data.chosen_index !== want.chosen_index) begin
						$display("%0t: chosen_index expected %0d, got %0d", $time,
							want.chosen_index, out_data.chosen_index);
						err_count++;
					end
					if (out_data.found !== want.found) begin
						$display("%0t: found expected %0b, got %0b", $time,
							want.found, out_data.found);
						err_count++;
					end
					if (out_data.estimate_value !== want.estimate_value) begin
						$display("%0t: estimate_value expected %0d, got %0d", $time,
							want.estimate_value, out_data.estimate_value);
						err_count++;
					end
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				rx_stall  = ($urandom_range(0, 3) == 0) ? idle_len(rx_calm) : 0;
				out_ready <= (rx_stall == 0);
			end
		end else
			out_ready <= 1'b0;
	end

	// Watchdog: too many cycles with no word moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_count = 0;
			else if (++quiet_count >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Waits until every job has been taken and every result word has come out.
	task automatic wait_drained();
		while (job_queue.size() != 0 || due_words.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic write_weight(logic [WEIGHT_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		blend_w   = v;
		n_weights++;
	endtask

	initial begin : stimulus
		logic [WEIGHT_W-1:0] weights [8];
		weights = '{4'd0, 4'd10, 4'd15, 4'd1, 4'd9, 4'd11, 4'd7, 4'd3};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset weight: empty table, extremes, ties.
		job_queue.push_back(make_job(FUNC_SELECT, 0, 1'b0, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_SET, 0, 1'b1, 1'b1, '0));
		job_queue.push_back(make_job(FUNC_SET, 63, 1'b1, 1'b0, '1));
		job_queue.push_back(make_job(FUNC_BURST, 63, 1'b1, 1'b0, '1));
		job_queue.push_back(make_job(FUNC_BURST, 0, 1'b1, 1'b1, 32'd100));
		job_queue.push_back(make_job(FUNC_SET, 5, 1'b1, 1'b1, '0));
		job_queue.push_back(make_job(FUNC_BURST, 7, 1'b1, 1'b0, 32'd50));
		job_queue.push_back(make_job(FUNC_BURST, 10, 1'b1, 1'b0, 32'd100));
		job_queue.push_back(make_job(FUNC_SELECT, 42, 1'b1, 1'b1, '1));
		job_queue.push_back(make_job(FUNC_SELECT, 0, 1'b0, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_SELECT, 0, 1'b0, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_SELECT, 0, 1'b0, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_SELECT, 0, 1'b0, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_SELECT, 0, 1'b0, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_NOP, 63, 1'b1, 1'b1, '1));
		job_queue.push_back(make_job(FUNC_NOP, 1, 1'b0, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_SET, 63, 1'b0, 1'b1, '0));
		job_queue.push_back(make_job(FUNC_BURST, 20, 1'b0, 1'b0, '1));
		job_queue.push_back(make_job(FUNC_BURST, 20, 1'b1, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_SELECT, 0, 1'b0, 1'b0, '0));
		job_queue.push_back(make_job(FUNC_SELECT, 0, 1'b0, 1'b0, '0));
		wait_drained();

		// Random phases, each under its own blend weight, zero and ten and
		// values above ten among them.
		foreach (weights[p]) begin
			write_weight(weights[p]);
			for (int k = 0; k < PHASE_WORDS; k++)
				job_queue.push_back(rand_job());
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (due_words.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, due_words.size());
			err_count++;
		end
		$display("summary: %0d words checked, %0d selects (%0d with nothing runnable)",
			n_words, n_selects, n_none);
		$display("summary: %0d burst updates over %0d blend weight settings",
			n_bursts, n_weights + 1);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
